// ===== rtl/pch_pkg.sv =====
// Package for the pair contingency histogram.
// Holds request and status codes, the report struct and default sizes.
// No dependencies.
package pch_pkg;

  localparam int DEF_MAX_CLUSTERS = 64;
  localparam int DEF_MAX_GROUPS   = 16;
  localparam int DEF_COUNT_BITS   = 32;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // word index of the single register on the APB port
  localparam logic REG_EXPECTED_GROUPS = 1'b0;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_FINISH = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NO_CELLS      = 3'd1,
    ST_BEYOND        = 3'd2,
    ST_GROUP_RANGE   = 3'd3,
    ST_CLUSTER_RANGE = 3'd4
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] rows;
    logic [7:0] cols;
    logic       warn;
  } report_t;

endpackage

// ===== rtl/pch_count_ram.sv =====
// Counter store of the pair contingency histogram.
// One write port and one registered read port. Depends on nothing.
module pch_count_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pch_stats.sv =====
// Range tracker of the pair contingency histogram: minimum and maximum of
// cluster and group, seen flags, and the status and table size they imply.
// Depends on pch_pkg.
module pch_stats
  import pch_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       upd,
  input  logic       upd_beyond,
  input  logic [7:0] upd_cluster,
  input  logic [7:0] upd_group,
  input  logic [7:0] expected_groups,
  output report_t    report
);

  logic [7:0] cluster_low, cluster_high, group_low, group_high;
  logic       any_seen, beyond_store;

  // fold each added cell into the ranges
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_low  <= 8'hFF;
      cluster_high <= 8'h00;
      group_low    <= 8'hFF;
      group_high   <= 8'h00;
      any_seen     <= 1'b0;
      beyond_store <= 1'b0;
    end else if (upd) begin
      if (upd_cluster < cluster_low)  cluster_low  <= upd_cluster;
      if (upd_cluster > cluster_high) cluster_high <= upd_cluster;
      if (upd_group < group_low)      group_low    <= upd_group;
      if (upd_group > group_high)     group_high   <= upd_group;
      any_seen <= 1'b1;
      if (upd_beyond) beyond_store <= 1'b1;
    end
  end

  // status by priority, then size and warning when clean
  always_comb begin
    report = '{status: ST_OK, rows: 8'h00, cols: 8'h00, warn: 1'b0};
    if (!any_seen) begin
      report.status = ST_NO_CELLS;
    end else if (beyond_store) begin
      report.status = ST_BEYOND;
    end else if (group_low != 8'd1 || group_high == group_low) begin
      report.status = ST_GROUP_RANGE;
    end else if (cluster_low != 8'd1 || cluster_high == cluster_low) begin
      report.status = ST_CLUSTER_RANGE;
    end else begin
      report.rows = cluster_high;
      report.cols = group_high;
      if (expected_groups != 8'h00) begin
        if (group_high > expected_groups) begin
          report.warn = 1'b1;
        end else begin
          report.cols = expected_groups;
        end
      end
    end
  end

endmodule

// ===== rtl/pair_contingency_histogram.sv =====
// Top level of the pair contingency histogram.
// Depends on pch_pkg, pch_count_ram and pch_stats.
//
// Input channel (in_valid / in_stall) carries one word per request: add a
// cell at (cluster, group), finish and report, or read one counter. Type 3
// is dropped. Output channel (out_valid / out_stall) carries one word for
// each finish or read: status, table size, warning flag and count. An add
// gives no output word.
//
// Flow: an accepted finish or read word goes from the pipeline stage into
// the output register once the output is free. Throughput: one request per
// cycle while in_stall is low, set by the single read-modify-write pass
// through the counter RAM; a back-to-back update of the same counter takes
// the written value from a bypass register.
//
// Reset: the ranges, flags and expected_groups clear at once; then a sweep
// writes zero to every counter, one per cycle, with in_stall high. APB
// writes are taken throughout.
//
// Receiver stall: the output word holds; one further finish or read waits
// in the pipeline stage and in_stall rises until the output drains. Adds
// keep flowing while the stage is free.
module pair_contingency_histogram
  import pch_pkg::*;
#(
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int MAX_GROUPS   = DEF_MAX_GROUPS,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  logic               clk,
  input  logic               rst,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [7:0]         cluster,
  input  logic [7:0]         group,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [7:0]         num_clusters,
  output logic [7:0]         num_groups,
  output logic               groups_exceed_expected,
  output logic [31:0]        count
);

  localparam int DEPTH  = MAX_CLUSTERS * MAX_GROUPS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0] expected_groups;

  // APB register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_groups <= 8'h00;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == REG_EXPECTED_GROUPS) begin
      expected_groups <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_EXPECTED_GROUPS) ? PDATA_W'(expected_groups)
                                                     : '0;

  // clearing sweep after reset
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // request decode
  logic              in_accept;
  logic              in_in_store;
  logic [15:0]       in_idx;
  logic [ADDR_W-1:0] in_addr;

  assign in_accept   = in_valid && !in_stall;
  assign in_in_store = cluster >= 8'd1 && 16'(cluster) <= 16'(MAX_CLUSTERS)
                    && group >= 8'd1 && 16'(group) <= 16'(MAX_GROUPS);
  assign in_idx      = 16'((16'(cluster) - 16'd1) * 16'(MAX_GROUPS)
                           + 16'(group) - 16'd1);
  assign in_addr     = in_idx[ADDR_W-1:0];

  // pipeline stage: RAM data arrives here
  logic                  s1_valid;
  req_t                  s1_req;
  logic [7:0]            s1_cluster, s1_group;
  logic [ADDR_W-1:0]     s1_addr;
  logic                  s1_in_store;
  logic                  s1_fwd;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [COUNT_BITS-1:0] rdata, s1_old, s1_wdata;
  logic                  s1_reports, s1_go, s1_wen;
  logic                  out_free;
  report_t               report;

  assign out_free   = !out_valid || !out_stall;
  assign s1_reports = s1_req == REQ_FINISH || s1_req == REQ_READ;
  assign s1_go      = s1_valid && (!s1_reports || out_free);
  assign s1_wen     = s1_go && s1_req == REQ_ADD && s1_in_store;
  assign in_stall   = clearing || (s1_valid && !s1_go);

  // saturating increment with bypass of the previous write
  assign s1_old   = s1_fwd ? fwd_data : rdata;
  assign s1_wdata = (s1_old == {COUNT_BITS{1'b1}}) ? s1_old : s1_old + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req      <= req_t'(req_type);
      s1_cluster  <= cluster;
      s1_group    <= group;
      s1_addr     <= in_addr;
      s1_in_store <= in_in_store;
      s1_fwd      <= s1_wen && s1_addr == in_addr;
      fwd_data    <= s1_wdata;
    end
  end

  pch_count_ram #(
    .DEPTH (DEPTH),
    .WIDTH (COUNT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (clearing || s1_wen),
    .waddr (clearing ? clr_addr : s1_addr),
    .wdata (clearing ? '0 : s1_wdata),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (rdata)
  );

  pch_stats u_stats (
    .clk             (clk),
    .rst             (rst),
    .upd             (s1_go && s1_req == REQ_ADD),
    .upd_beyond      (!s1_in_store),
    .upd_cluster     (s1_cluster),
    .upd_group       (s1_group),
    .expected_groups (expected_groups),
    .report          (report)
  );

  // count shown only inside the reported table and the store
  logic s1_count_ok;

  assign s1_count_ok = s1_req == REQ_READ && report.status == ST_OK
                    && s1_cluster >= 8'd1 && s1_cluster <= report.rows
                    && s1_group >= 8'd1 && s1_group <= report.cols
                    && s1_in_store;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_reports) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_reports) begin
      status                 <= report.status;
      num_clusters           <= report.rows;
      num_groups             <= report.cols;
      groups_exceed_expected <= report.warn;
      count                  <= s1_count_ok ? 32'(s1_old) : 32'h0;
    end
  end

endmodule

// ===== rtl/pch_checker.sv =====
// Port-level checks for the pair contingency histogram, bound to the top.
// Depends on pch_pkg and pair_contingency_histogram.
module pch_checker
  import pch_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         status,
  input logic [7:0]         num_clusters,
  input logic [7:0]         num_groups,
  input logic               groups_exceed_expected,
  input logic [31:0]        count
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(count)
      && $stable(num_clusters) && $stable(num_groups))
    else $error("output word changed under stall");

  // error status carries no size, warning or count
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> num_clusters == 8'h00 && num_groups == 8'h00
      && !groups_exceed_expected && count == 32'h0)
    else $error("error word carries data");

  // a clean report always has at least two rows and two columns
  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> num_clusters > 8'd1 && num_groups > 8'd1)
    else $error("clean report with degenerate size");

  // the counter sweep holds off requests right after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst && $past(rst) |-> in_stall && !out_valid)
    else $error("request taken during counter sweep");

endmodule

bind pair_contingency_histogram pch_checker u_pch_checker (.*);

// ===== bench/pch_table_checker.sv =====
// Checker for the pair contingency histogram: watches the APB port and both
// word channels, keeps its own copy of the count table and compares results.
// Depends on pch_pkg.
module pch_table_checker
  import pch_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [7:0]         cluster,
  input  logic [7:0]         group,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         status,
  input  logic [7:0]         num_clusters,
  input  logic [7:0]         num_groups,
  input  logic               groups_exceed_expected,
  input  logic [31:0]        count,
  output int                 outstanding,
  output int                 mismatches,
  output int                 compared
);

  localparam int STORE_DEPTH = DEF_MAX_CLUSTERS * DEF_MAX_GROUPS;
  localparam logic [DEF_COUNT_BITS-1:0] COUNT_CEIL = '1;

  typedef struct packed {
    status_t     st;
    logic [7:0]  rows;
    logic [7:0]  cols;
    logic        warn;
    logic [31:0] cnt;
  } report_word_t;

  // shadow of the block's table, ranges and register
  logic [DEF_COUNT_BITS-1:0] cell_count [STORE_DEPTH];
  logic [7:0]                clu_lo, clu_hi, grp_lo, grp_hi;
  logic                      any_cell, off_store;
  logic [7:0]                exp_groups;
  report_word_t              pending_reports [$];
  int                        err_cnt  = 0;
  int                        seen_cnt = 0;

  initial begin
    outstanding = 0;
    mismatches  = 0;
    compared    = 0;
  end

  function automatic bit in_store(logic [7:0] c, logic [7:0] g);
    return c >= 8'd1 && c <= DEF_MAX_CLUSTERS && g >= 8'd1 && g <= DEF_MAX_GROUPS;
  endfunction

  // Apply one request to the shadow table; return 1 with the report it yields.
  function automatic bit tally_request(req_t r, logic [7:0] c, logic [7:0] g,
                                       output report_word_t w);
    int ix;
    w  = '0;
    ix = (int'(c) - 1) * DEF_MAX_GROUPS + int'(g) - 1;
    case (r)
      REQ_ADD: begin
        if (c < clu_lo) clu_lo = c;
        if (c > clu_hi) clu_hi = c;
        if (g < grp_lo) grp_lo = g;
        if (g > grp_hi) grp_hi = g;
        any_cell = 1'b1;
        if (!in_store(c, g)) off_store = 1'b1;
        else if (cell_count[ix] != COUNT_CEIL) cell_count[ix] = cell_count[ix] + 1'b1;
        return 1'b0;
      end
      REQ_NOP: return 1'b0;
      default: ;
    endcase

    // status in priority order
    if (!any_cell)                                      w.st = ST_NO_CELLS;
    else if (off_store)                                 w.st = ST_BEYOND;
    else if (grp_lo != 8'd1 || grp_hi == grp_lo)        w.st = ST_GROUP_RANGE;
    else if (clu_lo != 8'd1 || clu_hi == clu_lo)        w.st = ST_CLUSTER_RANGE;
    else                                                w.st = ST_OK;

    if (w.st == ST_OK) begin
      w.rows = clu_hi;
      w.cols = grp_hi;
      if (exp_groups != 8'd0) begin
        if (grp_hi > exp_groups) w.warn = 1'b1;
        else w.cols = exp_groups;
      end
      if (r == REQ_READ && in_store(c, g) && c <= w.rows && g <= w.cols)
        w.cnt = cell_count[ix][31:0];
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    if (err_cnt <= 50)
      $display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    report_word_t want;
    report_word_t fresh;
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) cell_count[i] = '0;
      clu_lo     = 8'd255;
      clu_hi     = 8'd0;
      grp_lo     = 8'd255;
      grp_hi     = 8'd0;
      any_cell   = 1'b0;
      off_store  = 1'b0;
      exp_groups = 8'd0;
      pending_reports.delete();
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_EXPECTED_GROUPS)
        exp_groups = pwdata[7:0];

      // compare an accepted result word with the oldest report
      if (out_valid && !out_stall) begin
        seen_cnt++;
        if (pending_reports.size() == 0) begin
          report_mismatch("result word with none pending, status", status, 0);
        end else begin
          want = pending_reports.pop_front();
          if (status !== want.st)
            report_mismatch("status", status, want.st);
          if (num_clusters !== want.rows)
            report_mismatch("num_clusters", num_clusters, want.rows);
          if (num_groups !== want.cols)
            report_mismatch("num_groups", num_groups, want.cols);
          if (groups_exceed_expected !== want.warn)
            report_mismatch("groups_exceed_expected", groups_exceed_expected, want.warn);
          if (count !== want.cnt)
            report_mismatch("count", count, want.cnt);
        end
      end

      // predict from an accepted request word
      if (in_valid && !in_stall && tally_request(req_t'(req_type), cluster, group, fresh))
        pending_reports.push_back(fresh);
    end
    outstanding <= pending_reports.size();
    mismatches  <= err_cnt;
    compared    <= seen_cnt;
  end

endmodule

// ===== bench/tb_pair_contingency_histogram.sv =====
// Testbench top for the pair contingency histogram: clock, reset, request
// stimulus, receiver stalls, APB writes and the verdict.
// Depends on pch_pkg, pair_contingency_histogram and pch_table_checker.
module tb_pair_contingency_histogram;
  import pch_pkg::*;

  localparam logic [PADDR_W-1:0] EXP_GROUPS_ADDR = PADDR_W'(REG_EXPECTED_GROUPS) << 2;

  typedef enum logic [1:0] {
    RX_FREE  = 2'd0,
    RX_LIGHT = 2'd1,
    RX_HEAVY = 2'd2,
    RX_CHOKE = 2'd3
  } rx_mode_t;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type  = REQ_NOP;
  logic [7:0]         cluster   = '0;
  logic [7:0]         group     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic [7:0]         num_clusters;
  logic [7:0]         num_groups;
  logic               groups_exceed_expected;
  logic [31:0]        count;

  int       outstanding;
  int       mismatches;
  int       compared;
  int       burst_left = 0;
  int       n_sent     = 0;
  int       n_settings = 0;
  rx_mode_t rx_mode    = RX_FREE;
  int       mode_left  = 0;

  pair_contingency_histogram dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .cluster(cluster), .group(group),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .num_clusters(num_clusters), .num_groups(num_groups),
    .groups_exceed_expected(groups_exceed_expected), .count(count)
  );

  pch_table_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .cluster(cluster), .group(group),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .num_clusters(num_clusters), .num_groups(num_groups),
    .groups_exceed_expected(groups_exceed_expected), .count(count),
    .outstanding(outstanding), .mismatches(mismatches), .compared(compared)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: switch at random between stall modes
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(32, 200);
      out_stall <= 1'b0;
    end else begin
      mode_left <= mode_left - 1;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // Present one request word in bursts; hold it until accepted.
  task automatic pace_and_issue(req_t r, logic [7:0] c, logic [7:0] g);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= r;
    cluster  <= c;
    group    <= g;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // Drop valid and wait until every report has come back, plus the latency.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_expected_groups(logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EXP_GROUPS_ADDR;
    pwdata  <= {{(PDATA_W-8){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_settings++;
  endtask

  // Mostly a small index so counters build up; sometimes the full store.
  function automatic logic [7:0] pick(int narrow, int full);
    return 8'($urandom_range(1, ($urandom_range(0, 4) == 0) ? full : narrow));
  endfunction

  task automatic random_request(bit anywhere);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      if (anywhere && $urandom_range(0, 1) == 1)
        pace_and_issue(REQ_ADD, 8'($urandom), 8'($urandom));
      else
        pace_and_issue(REQ_ADD, pick(8, DEF_MAX_CLUSTERS), pick(4, DEF_MAX_GROUPS));
    end else if (roll < 87) begin
      if ($urandom_range(0, 9) < 3)
        pace_and_issue(REQ_READ, 8'($urandom), 8'($urandom));
      else
        pace_and_issue(REQ_READ, pick(8, DEF_MAX_CLUSTERS), pick(4, DEF_MAX_GROUPS + 2));
    end else if (roll < 95) begin
      pace_and_issue(REQ_FINISH, 8'($urandom), 8'($urandom));
    end else begin
      pace_and_issue(REQ_NOP, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] grp_cfg [8];
    grp_cfg = '{8'd255, 8'd1, 8'd16, 8'd0, 8'd2, 8'd0, 8'd8, 8'd17};
    grp_cfg[5] = 8'($urandom_range(3, 254));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_expected_groups(8'd0);

    // empty table, then a dropped request type
    pace_and_issue(REQ_FINISH, 8'd0, 8'd0);
    pace_and_issue(REQ_READ, 8'd0, 8'd0);
    pace_and_issue(REQ_READ, 8'd255, 8'd255);
    pace_and_issue(REQ_NOP, 8'hAA, 8'h55);
    // one group only, then one cluster only starting above 1
    pace_and_issue(REQ_ADD, 8'd2, 8'd1);
    pace_and_issue(REQ_FINISH, 8'd0, 8'd0);
    pace_and_issue(REQ_READ, 8'd2, 8'd1);
    pace_and_issue(REQ_ADD, 8'd2, 8'd2);
    pace_and_issue(REQ_FINISH, 8'd0, 8'd0);
    // valid table; reads inside, on a zero index and past the size
    pace_and_issue(REQ_ADD, 8'd1, 8'd3);
    pace_and_issue(REQ_FINISH, 8'd0, 8'd0);
    pace_and_issue(REQ_READ, 8'd1, 8'd3);
    pace_and_issue(REQ_READ, 8'd2, 8'd1);
    pace_and_issue(REQ_READ, 8'd0, 8'd1);
    pace_and_issue(REQ_READ, 8'd3, 8'd1);
    pace_and_issue(REQ_READ, 8'd1, 8'd4);
    pace_and_issue(REQ_READ, 8'd1, 8'd0);
    // back-to-back updates of one counter, read right behind them
    pace_and_issue(REQ_ADD, 8'd1, 8'd3);
    pace_and_issue(REQ_ADD, 8'd1, 8'd3);
    pace_and_issue(REQ_READ, 8'd1, 8'd3);
    // far corner of the store
    pace_and_issue(REQ_ADD, 8'(DEF_MAX_CLUSTERS), 8'(DEF_MAX_GROUPS));
    pace_and_issue(REQ_ADD, 8'(DEF_MAX_CLUSTERS), 8'(DEF_MAX_GROUPS));
    pace_and_issue(REQ_READ, 8'(DEF_MAX_CLUSTERS), 8'(DEF_MAX_GROUPS));
    pace_and_issue(REQ_FINISH, 8'd0, 8'd0);

    // random traffic under each expected_groups setting
    for (int p = 0; p < 8; p++) begin
      settle();
      set_expected_groups(grp_cfg[p]);
      repeat (120) random_request(1'b0);
    end

    // cells off the store: every later report carries the beyond-store status
    settle();
    pace_and_issue(REQ_ADD, 8'd0, 8'd5);
    pace_and_issue(REQ_FINISH, 8'd0, 8'd0);
    pace_and_issue(REQ_ADD, 8'd255, 8'd255);
    pace_and_issue(REQ_ADD, 8'(DEF_MAX_CLUSTERS + 1), 8'd1);
    pace_and_issue(REQ_ADD, 8'd1, 8'(DEF_MAX_GROUPS + 1));
    pace_and_issue(REQ_ADD, 8'd5, 8'd0);
    pace_and_issue(REQ_READ, 8'd1, 8'd3);
    repeat (60) random_request(1'b1);

    settle();
    repeat (4) @(posedge clk);
    $display("Summary: %0d request words over %0d expected_groups settings, %0d results checked",
             n_sent, n_settings, compared);
    $display("Summary: empty, range-error, valid and off-store tables; reads in and out of bounds");
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
